// ===== rtl/tvm_pkg.sv =====
package tvm_pkg;

	localparam int FUNCW  = 2;
	localparam int ADDRW  = 10;
	localparam int OPW    = 5;
	localparam int REG_FW = 3;
	localparam int VALW   = 32;
	localparam int STATW  = 2;

	// host functions
	localparam logic [FUNCW-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNCW-1:0] FUNC_SETPC = 2'd1;
	localparam logic [FUNCW-1:0] FUNC_STEP  = 2'd2;
	localparam logic [FUNCW-1:0] FUNC_READ  = 2'd3;

	// status codes
	localparam logic [STATW-1:0] ST_OK      = 2'd0;
	localparam logic [STATW-1:0] ST_RANGE   = 2'd1;
	localparam logic [STATW-1:0] ST_ILLEGAL = 2'd2;

	// opcodes
	localparam logic [OPW-1:0] OP_DATA  = 5'd0;
	localparam logic [OPW-1:0] OP_LDI   = 5'd1;
	localparam logic [OPW-1:0] OP_STD   = 5'd2;
	localparam logic [OPW-1:0] OP_ADD   = 5'd3;
	localparam logic [OPW-1:0] OP_ADDI  = 5'd4;
	localparam logic [OPW-1:0] OP_STX   = 5'd5;
	localparam logic [OPW-1:0] OP_SUB   = 5'd6;
	localparam logic [OPW-1:0] OP_JMPIG = 5'd7;
	localparam logic [OPW-1:0] OP_JMP   = 5'd8;
	localparam logic [OPW-1:0] OP_JMPI  = 5'd9;
	localparam logic [OPW-1:0] OP_JMPIL = 5'd10;
	localparam logic [OPW-1:0] OP_JMPIE = 5'd11;
	localparam logic [OPW-1:0] OP_SWAP  = 5'd12;
	localparam logic [OPW-1:0] OP_SUBI  = 5'd13;
	localparam logic [OPW-1:0] OP_MULT  = 5'd14;
	localparam logic [OPW-1:0] OP_LDD   = 5'd15;
	localparam logic [OPW-1:0] OP_STOP  = 5'd16;

	typedef struct packed {
		logic [FUNCW-1:0]       func;
		logic [ADDRW-1:0]       address;
		logic [OPW-1:0]         opcode;
		logic [REG_FW-1:0]      reg_a;
		logic [REG_FW-1:0]      reg_b;
		logic signed [VALW-1:0] value;
	} req_t;

	typedef struct packed {
		logic [ADDRW-1:0]       pc;
		logic                   halted;
		logic [STATW-1:0]       status;
		logic [OPW-1:0]         word_opcode;
		logic [REG_FW-1:0]      word_reg_a;
		logic [REG_FW-1:0]      word_reg_b;
		logic signed [VALW-1:0] word_value;
	} rsp_t;

	typedef struct packed {
		logic [OPW-1:0]    opcode;
		logic [REG_FW-1:0] reg_a;
		logic [REG_FW-1:0] reg_b;
		logic [VALW-1:0]   value;
	} word_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic fetch;
		logic exec;
		logic load;
		logic swap2;
		logic put;
	} tvm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_fetch;
		logic req_step;
		logic go_ldd;
		logic go_swap;
		logic out_free;
	} tvm_sts_t;

endpackage

// ===== rtl/toy_vm_instruction_step.sv =====
// Toy register machine: program memory, register file and program counter,
// driven one host request at a time.
// Request channel (req_valid / req_stall / req): func 0 writes a memory word,
// func 1 sets the program counter and clears the halt flag, func 2 fetches
// and executes one instruction, func 3 reads a memory word back.
// Response channel (rsp_valid / rsp_stall / rsp): one response per request,
// in order, with pc, halt flag, status and the word read by func 3.
// Path from accept to response: func 0, func 1 and a step while halted go
// straight to the response state; func 3 passes through fetch; a step
// through fetch and execute, and LDD or SWAP adds a load or swap state.
// A new request is taken in the cycle the previous response is loaded. The
// states follow the synchronous memory read for fetch, the register file
// read, and one more memory read for LDD or a second register write for SWAP.
// Reset clears the registers, the program counter and the halt flag at once;
// program memory holds no defined value until written.
// While the receiver stalls, the response holds; the block finishes the
// request in progress and then stalls the request side until the response
// is taken.
module toy_vm_instruction_step import tvm_pkg::*; #(
	parameter int MEM_WORDS = 1024,
	parameter int NUM_REGS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	tvm_cmd_t cmd;
	tvm_sts_t sts;

	tvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tvm_dp #(
		.MEM_WORDS(MEM_WORDS),
		.NUM_REGS (NUM_REGS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall)
	);

endmodule

// ===== rtl/tvm_ctrl.sv =====
module tvm_ctrl import tvm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  tvm_sts_t sts,
	output tvm_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FETCH = 6'b000010,
		S_EXEC  = 6'b000100,
		S_LOAD  = 6'b001000,
		S_SWAP  = 6'b010000,
		S_PUT   = 6'b100000
	} state_t;

	state_t state_q, state_d, entry;
	logic   open, accept;

	// a new request is taken while the previous response goes out
	assign open      = (state_q == S_IDLE) || ((state_q == S_PUT) && sts.out_free);
	assign req_stall = !open;
	assign accept    = req_valid && open;
	assign entry     = sts.in_fetch ? S_FETCH : S_PUT;

	always_comb begin
		cmd.accept = accept;
		cmd.fetch  = (state_q == S_FETCH);
		cmd.exec   = (state_q == S_EXEC);
		cmd.load   = (state_q == S_LOAD);
		cmd.swap2  = (state_q == S_SWAP);
		cmd.put    = (state_q == S_PUT) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = entry;
			end
			S_FETCH: begin
				state_d = sts.req_step ? S_EXEC : S_PUT;
			end
			S_EXEC: begin
				if (sts.go_ldd) state_d = S_LOAD;
				else if (sts.go_swap) state_d = S_SWAP;
				else state_d = S_PUT;
			end
			S_LOAD, S_SWAP: begin
				state_d = S_PUT;
			end
			S_PUT: begin
				if (sts.out_free) state_d = accept ? entry : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	a_exec_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> ($past(state_q) == S_FETCH))
		else $error("execute state entered without a fetch");

endmodule

// ===== rtl/tvm_rf.sv =====
module tvm_rf import tvm_pkg::*; #(
	parameter int NUM_REGS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              re,
	input  logic [REG_FW-1:0] idx_a,
	input  logic [REG_FW-1:0] idx_b,
	output logic [VALW-1:0]   rdata_a,
	output logic [VALW-1:0]   rdata_b,
	input  logic              we,
	input  logic [REG_FW-1:0] widx,
	input  logic [VALW-1:0]   wdata
);

	localparam int RW = $clog2(NUM_REGS);
	localparam logic [31:0] REG_LIM = 32'(NUM_REGS);

	logic [VALW-1:0]     mem_q [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [VALW-1:0]     rd_a_q, rd_b_q;
	logic [31:0]         ia32, ib32, iw32;
	logic                a_hit, b_hit, w_ok;

	assign ia32  = 32'(idx_a);
	assign ib32  = 32'(idx_b);
	assign iw32  = 32'(widx);
	assign a_hit = (ia32 < REG_LIM) && vld_q[ia32[RW-1:0]];
	assign b_hit = (ib32 < REG_LIM) && vld_q[ib32[RW-1:0]];
	assign w_ok  = we && (iw32 < REG_LIM);

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (w_ok) vld_q[iw32[RW-1:0]] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (w_ok) mem_q[iw32[RW-1:0]] <= wdata;
		if (re) begin
			rd_a_q <= a_hit ? mem_q[ia32[RW-1:0]] : '0;
			rd_b_q <= b_hit ? mem_q[ib32[RW-1:0]] : '0;
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (iw32 < REG_LIM))
		else $error("register write beyond the register file");

endmodule

// ===== rtl/tvm_dp.sv =====
module tvm_dp import tvm_pkg::*; #(
	parameter int MEM_WORDS = 1024,
	parameter int NUM_REGS  = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  tvm_cmd_t cmd,
	output tvm_sts_t sts,
	input  req_t     req,
	output rsp_t     rsp,
	output logic     rsp_valid,
	input  logic     rsp_stall
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [31:0] MEM_LIM = 32'(MEM_WORDS);
	localparam logic [31:0] REG_LIM = 32'(NUM_REGS);

	// program memory: opcode and value in one array, register fields in another,
	// so a store can leave the register fields alone
	logic [OPW+VALW-1:0] mem_ov [MEM_WORDS];
	logic [2*REG_FW-1:0] mem_ab [MEM_WORDS];
	logic [OPW+VALW-1:0] rd_ov_q;
	logic [2*REG_FW-1:0] rd_ab_q;
	word_t               rdata;

	logic          ov_we, ab_we, rd_en;
	logic [AW-1:0] w_idx, r_idx;
	word_t         w_word;

	req_t            req_q;
	word_t           ir_q, word_q;
	logic [AW-1:0]   pc_q;
	logic            halt_q;
	logic [STATW-1:0] status_q;
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	logic [31:0]   req_a32;
	logic          req_in_mem;
	logic [AW-1:0] req_idx;
	logic [AW:0]   pc_inc;
	logic [31:0]   pc_inc32, pc32;
	logic [AW-1:0] pc_next;

	logic [VALW-1:0] ra, rb;
	logic            rf_we;
	logic [REG_FW-1:0] rf_widx;
	logic [VALW-1:0] rf_wdata;

	// execute decode
	logic [OPW-1:0]  op;
	logic            uses_b, a_bad, b_bad, illegal, take;
	logic            ex_fault, ex_adv, ex_jump, ex_rf_we, ex_st_we, ex_ld, ex_swap;
	logic [STATW-1:0] ex_status;
	logic [VALW-1:0] ex_rf_data, ex_st_addr, ex_st_val, ex_tgt;

	assign req_a32    = 32'(req.address);
	assign req_in_mem = req_a32 < MEM_LIM;
	assign req_idx    = req_a32[AW-1:0];

	assign pc_inc   = {1'b0, pc_q} + 1'b1;
	assign pc_inc32 = 32'(pc_inc);
	assign pc_next  = (pc_inc32 >= MEM_LIM) ? '0 : pc_inc[AW-1:0];
	assign pc32     = 32'(pc_q);

	assign rdata = {rd_ov_q[OPW+VALW-1:VALW], rd_ab_q, rd_ov_q[VALW-1:0]};

	assign op      = ir_q.opcode;
	assign uses_b  = op inside {OP_ADD, OP_STX, OP_SUB, OP_JMPIG, OP_JMPIL, OP_JMPIE,
		OP_SWAP, OP_MULT};
	assign a_bad   = 32'(ir_q.reg_a) >= REG_LIM;
	assign b_bad   = 32'(ir_q.reg_b) >= REG_LIM;
	assign illegal = (op == OP_DATA) || (op > OP_STOP) || ((op != OP_JMP) && a_bad) ||
		(uses_b && b_bad);

	always_comb begin
		ex_fault   = 1'b0;
		ex_status  = ST_OK;
		ex_adv     = 1'b1;
		ex_jump    = 1'b0;
		ex_rf_we   = 1'b0;
		ex_rf_data = ra;
		ex_st_we   = 1'b0;
		ex_st_addr = ir_q.value;
		ex_st_val  = ra;
		ex_ld      = 1'b0;
		ex_swap    = 1'b0;
		ex_tgt     = ra;
		take       = 1'b0;
		if (op == OP_STOP) begin
			ex_fault = 1'b1;
			ex_adv   = 1'b0;
		end else if (illegal) begin
			ex_fault  = 1'b1;
			ex_status = ST_ILLEGAL;
			ex_adv    = 1'b0;
		end else begin
			case (op)
				OP_LDI: begin
					ex_rf_we   = 1'b1;
					ex_rf_data = ir_q.value;
				end
				OP_ADD: begin
					ex_rf_we   = 1'b1;
					ex_rf_data = ra + rb;
				end
				OP_ADDI: begin
					ex_rf_we   = 1'b1;
					ex_rf_data = ra + ir_q.value;
				end
				OP_SUB: begin
					ex_rf_we   = 1'b1;
					ex_rf_data = ra - rb;
				end
				OP_SUBI: begin
					ex_rf_we   = 1'b1;
					ex_rf_data = ra - ir_q.value;
				end
				OP_MULT: begin
					ex_rf_we   = 1'b1;
					ex_rf_data = ra * rb;
				end
				OP_SWAP: begin
					ex_rf_we   = 1'b1;
					ex_rf_data = rb;
					ex_swap    = 1'b1;
				end
				OP_STD, OP_STX: begin
					ex_st_addr = (op == OP_STD) ? ir_q.value : ra;
					ex_st_val  = (op == OP_STD) ? ra : rb;
					if (ex_st_addr < MEM_LIM) begin
						ex_st_we = 1'b1;
					end else begin
						ex_fault  = 1'b1;
						ex_status = ST_RANGE;
						ex_adv    = 1'b0;
					end
				end
				OP_LDD: begin
					if (ir_q.value < MEM_LIM) begin
						ex_ld = 1'b1;
					end else begin
						ex_fault  = 1'b1;
						ex_status = ST_RANGE;
						ex_adv    = 1'b0;
					end
				end
				default: begin
					// jumps
					if (op == OP_JMPIG) take = (rb != '0) && !rb[VALW-1];
					else if (op == OP_JMPIL) take = rb[VALW-1];
					else if (op == OP_JMPIE) take = (rb == '0);
					else take = 1'b1;
					ex_tgt = (op == OP_JMP) ? ir_q.value : ra;
					if (take) begin
						ex_adv = 1'b0;
						if (ex_tgt < MEM_LIM) begin
							ex_jump = 1'b1;
						end else begin
							ex_fault  = 1'b1;
							ex_status = ST_RANGE;
						end
					end
				end
			endcase
		end
	end

	// memory port selection
	always_comb begin
		ov_we  = 1'b0;
		ab_we  = 1'b0;
		w_idx  = req_idx;
		w_word = {req.opcode, req.reg_a, req.reg_b, req.value};
		if (cmd.accept && (req.func == FUNC_LOAD) && req_in_mem) begin
			ov_we = 1'b1;
			ab_we = 1'b1;
		end else if (cmd.exec && ex_st_we) begin
			ov_we  = 1'b1;
			w_idx  = ex_st_addr[AW-1:0];
			w_word = {OP_DATA, {2*REG_FW{1'b0}}, ex_st_val};
		end
	end

	always_comb begin
		rd_en = 1'b0;
		r_idx = req_idx;
		if (cmd.exec) begin
			rd_en = ex_ld;
			r_idx = ir_q.value[AW-1:0];
		end else if (cmd.accept) begin
			if ((req.func == FUNC_STEP) && !halt_q) begin
				rd_en = 1'b1;
				r_idx = pc_q;
			end else if ((req.func == FUNC_READ) && req_in_mem) begin
				rd_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ov_we) mem_ov[w_idx] <= {w_word.opcode, w_word.value};
		if (ab_we) mem_ab[w_idx] <= {w_word.reg_a, w_word.reg_b};
		if (rd_en) begin
			rd_ov_q <= mem_ov[r_idx];
			rd_ab_q <= mem_ab[r_idx];
		end
	end

	// register file
	always_comb begin
		rf_we    = (cmd.exec && ex_rf_we) || cmd.load || cmd.swap2;
		rf_widx  = cmd.swap2 ? ir_q.reg_b : ir_q.reg_a;
		rf_wdata = ex_rf_data;
		if (cmd.load) rf_wdata = rdata.value;
		else if (cmd.swap2) rf_wdata = ra;
	end

	tvm_rf #(
		.NUM_REGS(NUM_REGS)
	) u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (cmd.fetch),
		.idx_a  (rdata.reg_a),
		.idx_b  (rdata.reg_b),
		.rdata_a(ra),
		.rdata_b(rb),
		.we     (rf_we),
		.widx   (rf_widx),
		.wdata  (rf_wdata)
	);

	// machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			halt_q <= 1'b0;
		end else begin
			if (cmd.accept && (req.func == FUNC_SETPC) && req_in_mem) begin
				pc_q   <= req_idx;
				halt_q <= 1'b0;
			end
			if (cmd.exec) begin
				if (ex_fault) halt_q <= 1'b1;
				if (ex_jump) pc_q <= ex_tgt[AW-1:0];
				else if (ex_adv) pc_q <= pc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q    <= req;
			word_q   <= '0;
			status_q <= ((req.func != FUNC_STEP) && !req_in_mem) ? ST_RANGE : ST_OK;
		end
		if (cmd.fetch) begin
			ir_q <= rdata;
			if ((req_q.func == FUNC_READ) && (status_q == ST_OK)) word_q <= rdata;
		end
		if (cmd.exec) status_q <= ex_status;
		if (cmd.put) begin
			rsp_q.pc          <= pc32[ADDRW-1:0];
			rsp_q.halted      <= halt_q;
			rsp_q.status      <= status_q;
			rsp_q.word_opcode <= word_q.opcode;
			rsp_q.word_reg_a  <= word_q.reg_a;
			rsp_q.word_reg_b  <= word_q.reg_b;
			rsp_q.word_value  <= word_q.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (cmd.put) rsp_valid_q <= 1'b1;
		else if (!rsp_stall) rsp_valid_q <= 1'b0;
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		sts.in_fetch = ((req.func == FUNC_STEP) && !halt_q) || (req.func == FUNC_READ);
		sts.req_step = (req_q.func == FUNC_STEP);
		sts.go_ldd   = ex_ld;
		sts.go_swap  = ex_swap;
		sts.out_free = !rsp_valid_q || !rsp_stall;
	end

	a_mem_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_we || ab_we) |-> (32'(w_idx) < MEM_LIM))
		else $error("program memory write beyond the memory");

	a_put_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |=> rsp_valid)
		else $error("loaded response not presented");

	a_load_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> $past(cmd.exec && ex_ld))
		else $error("memory load finished without a decoded load");

endmodule
